// ===== sv/uart_rx_tx_ring_buffer_assert.svh =====
// Assertion macros for the serial-port ring buffer.
// ASSERT_CLK checks an expression at every rising clock edge outside reset.
// ASSERT_IMP checks that an antecedent implies a consequent in the same cycle.
// ASSERT_NXT checks that an antecedent implies a consequent in the next cycle.
`ifndef UART_RX_TX_RING_BUFFER_ASSERT_SVH
`define UART_RX_TX_RING_BUFFER_ASSERT_SVH

`ifndef SYNTHESIS

`define ASSERT_CLK(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) else $error(msg);

`define ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`define ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`else

`define ASSERT_CLK(lbl, expr, msg)
`define ASSERT_IMP(lbl, ante, cons, msg)
`define ASSERT_NXT(lbl, ante, cons, msg)

`endif

`endif

// ===== sv/urtrb_pkg.sv =====
`default_nettype none

package urtrb_pkg;

  localparam int DATA_W      = 8;
  localparam int ACT_W       = 3;
  localparam int CFG_W       = 7;
  localparam int FILL_W      = 6;
  localparam int CFG_IDX_W   = 1;
  localparam int RX_DEPTH_DEF = 64;
  localparam int TX_DEPTH_DEF = 64;

  localparam logic [CFG_W-1:0] SIZE_RESET = 7'd64;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RX_RING_SIZE = 1'b0,
    REG_TX_RING_SIZE = 1'b1
  } cfg_reg_e;

  typedef enum logic [ACT_W-1:0] {
    ACT_RX_BYTE    = 3'd0,
    ACT_HOST_READ  = 3'd1,
    ACT_HOST_PEEK  = 3'd2,
    ACT_HOST_WRITE = 3'd3,
    ACT_TX_READY   = 3'd4
  } action_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } ctl_state_e;

  typedef struct packed {
    logic capture;
    logic commit;
  } ctl_cmd_t;

endpackage

`default_nettype wire

// ===== sv/urtrb_ram.sv =====
`default_nettype none

module urtrb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== sv/urtrb_ctl.sv =====
`default_nettype none

module urtrb_ctl
  import urtrb_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_stall_o,
  output logic      out_valid_o,
  input  wire logic out_stall_i,
  output ctl_cmd_t  cmd_o
);

  ctl_state_e state_q, state_d;
  logic       out_valid_q, out_valid_d;
  ctl_cmd_t   cmd;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (!out_valid_q || !out_stall_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd        = '0;
    in_stall_o = 1'b1;
    case (state_q)
      ST_IDLE: begin
        in_stall_o  = 1'b0;
        cmd.capture = in_valid_i;
      end
      ST_EXEC: begin
        // commit only once the result register is free or being emptied
        cmd.commit = !out_valid_q || !out_stall_i;
      end
      default: begin
        cmd = '0;
      end
    endcase
    out_valid_d = cmd.commit || (out_valid_q && out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign cmd_o       = cmd;

endmodule

`default_nettype wire

// ===== sv/urtrb_dp.sv =====
`default_nettype none

module urtrb_dp
  import urtrb_pkg::*;
#(
  parameter int RX_DEPTH = RX_DEPTH_DEF,
  parameter int TX_DEPTH = TX_DEPTH_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire ctl_cmd_t             cmd_i,
  input  wire logic [ACT_W-1:0]     action_i,
  input  wire logic [DATA_W-1:0]    data_byte_i,
  input  wire logic                 tx_idle_i,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [CFG_W-1:0]     cfg_data_i,
  output logic      [DATA_W-1:0]    read_data_o,
  output logic                      read_valid_o,
  output logic                      write_accepted_o,
  output logic      [DATA_W-1:0]    send_data_o,
  output logic                      send_valid_o,
  output logic                      rx_dropped_o,
  output logic      [FILL_W-1:0]    rx_fill_o,
  output logic      [FILL_W-1:0]    tx_fill_o
);

  localparam int RX_PW = $clog2(RX_DEPTH);
  localparam int RX_EW = RX_PW + 1;
  localparam int RX_CW = (RX_EW > CFG_W) ? RX_EW : CFG_W;
  localparam int TX_PW = $clog2(TX_DEPTH);
  localparam int TX_EW = TX_PW + 1;
  localparam int TX_CW = (TX_EW > CFG_W) ? TX_EW : CFG_W;

  // captured item
  logic [ACT_W-1:0]  action_q;
  logic [DATA_W-1:0] data_q;
  logic              idle_q;

  // ring sizes and positions
  logic [CFG_W-1:0] rx_size_q, tx_size_q;
  logic [RX_PW-1:0] rx_wp_q, rx_wp_d, rx_rp_q, rx_rp_d;
  logic [TX_PW-1:0] tx_wp_q, tx_wp_d, tx_rp_q, tx_rp_d;

  // result register
  logic [DATA_W-1:0] read_data_q, read_data_d;
  logic              read_valid_q, read_valid_d;
  logic              accepted_q, accepted_d;
  logic [DATA_W-1:0] send_data_q, send_data_d;
  logic              send_valid_q, send_valid_d;
  logic              dropped_q, dropped_d;
  logic [FILL_W-1:0] rx_fill_q, rx_fill_d;
  logic [FILL_W-1:0] tx_fill_q, tx_fill_d;

  logic [RX_CW-1:0]  rx_size_ext;
  logic [TX_CW-1:0]  tx_size_ext;
  logic [RX_EW-1:0]  rx_eff, rx_wp_inc, rx_rp_inc, rx_fill_ew;
  logic [TX_EW-1:0]  tx_eff, tx_wp_inc, tx_rp_inc, tx_fill_ew;
  logic [RX_PW-1:0]  rx_wnext, rx_rnext;
  logic [TX_PW-1:0]  tx_wnext, tx_rnext;
  logic              rx_empty, tx_empty;
  logic              rx_we, tx_we;
  logic [DATA_W-1:0] rx_rdata, tx_rdata;

  // effective sizes, clamped to [2, depth]
  assign rx_size_ext = RX_CW'(rx_size_q);
  assign tx_size_ext = TX_CW'(tx_size_q);
  assign rx_eff = (rx_size_ext < RX_CW'(2))        ? RX_EW'(2) :
                  (rx_size_ext > RX_CW'(RX_DEPTH)) ? RX_EW'(RX_DEPTH) :
                                                     RX_EW'(rx_size_ext);
  assign tx_eff = (tx_size_ext < TX_CW'(2))        ? TX_EW'(2) :
                  (tx_size_ext > TX_CW'(TX_DEPTH)) ? TX_EW'(TX_DEPTH) :
                                                     TX_EW'(tx_size_ext);

  // wrap increments
  assign rx_wp_inc = {1'b0, rx_wp_q} + RX_EW'(1);
  assign rx_rp_inc = {1'b0, rx_rp_q} + RX_EW'(1);
  assign tx_wp_inc = {1'b0, tx_wp_q} + TX_EW'(1);
  assign tx_rp_inc = {1'b0, tx_rp_q} + TX_EW'(1);
  assign rx_wnext  = (rx_wp_inc == rx_eff) ? '0 : rx_wp_inc[RX_PW-1:0];
  assign rx_rnext  = (rx_rp_inc == rx_eff) ? '0 : rx_rp_inc[RX_PW-1:0];
  assign tx_wnext  = (tx_wp_inc == tx_eff) ? '0 : tx_wp_inc[TX_PW-1:0];
  assign tx_rnext  = (tx_rp_inc == tx_eff) ? '0 : tx_rp_inc[TX_PW-1:0];

  assign rx_empty = (rx_wp_q == rx_rp_q);
  assign tx_empty = (tx_wp_q == tx_rp_q);

  urtrb_ram #(
    .WIDTH (DATA_W),
    .DEPTH (RX_DEPTH)
  ) u_rx_ram (
    .clk_i   (clk_i),
    .we_i    (rx_we),
    .waddr_i (rx_wp_q),
    .wdata_i (data_q),
    .raddr_i (rx_rp_q),
    .rdata_o (rx_rdata)
  );

  urtrb_ram #(
    .WIDTH (DATA_W),
    .DEPTH (TX_DEPTH)
  ) u_tx_ram (
    .clk_i   (clk_i),
    .we_i    (tx_we),
    .waddr_i (tx_wp_q),
    .wdata_i (data_q),
    .raddr_i (tx_rp_q),
    .rdata_o (tx_rdata)
  );

  // step logic; read data is valid from the cycle after capture
  always_comb begin
    rx_wp_d      = rx_wp_q;
    rx_rp_d      = rx_rp_q;
    tx_wp_d      = tx_wp_q;
    tx_rp_d      = tx_rp_q;
    rx_we        = 1'b0;
    tx_we        = 1'b0;
    read_data_d  = '0;
    read_valid_d = 1'b0;
    accepted_d   = 1'b0;
    send_data_d  = '0;
    send_valid_d = 1'b0;
    dropped_d    = 1'b0;
    case (action_q)
      ACT_RX_BYTE: begin
        rx_we   = cmd_i.commit;
        rx_wp_d = rx_wnext;
        if (rx_wnext == rx_rp_q) begin
          rx_rp_d   = rx_rnext;
          dropped_d = 1'b1;
        end
      end
      ACT_HOST_READ, ACT_HOST_PEEK: begin
        if (!rx_empty) begin
          read_data_d  = rx_rdata;
          read_valid_d = 1'b1;
          if (action_q == ACT_HOST_READ) begin
            rx_rp_d = rx_rnext;
          end
        end
      end
      ACT_HOST_WRITE: begin
        if (tx_empty && idle_q) begin
          send_data_d  = data_q;
          send_valid_d = 1'b1;
          accepted_d   = 1'b1;
        end else if (tx_wnext != tx_rp_q) begin
          tx_we      = cmd_i.commit;
          tx_wp_d    = tx_wnext;
          accepted_d = 1'b1;
          // ring cannot be empty here when idle, so the kick always pops
          if (idle_q) begin
            send_data_d  = tx_rdata;
            send_valid_d = 1'b1;
            tx_rp_d      = tx_rnext;
          end
        end
      end
      ACT_TX_READY: begin
        if (!tx_empty) begin
          send_data_d  = tx_rdata;
          send_valid_d = 1'b1;
          tx_rp_d      = tx_rnext;
        end
      end
      default: begin
        rx_we = 1'b0;
      end
    endcase

    rx_fill_ew = (rx_wp_d >= rx_rp_d) ? ({1'b0, rx_wp_d} - {1'b0, rx_rp_d})
                                      : (rx_eff + {1'b0, rx_wp_d} - {1'b0, rx_rp_d});
    tx_fill_ew = (tx_wp_d >= tx_rp_d) ? ({1'b0, tx_wp_d} - {1'b0, tx_rp_d})
                                      : (tx_eff + {1'b0, tx_wp_d} - {1'b0, tx_rp_d});
    rx_fill_d  = FILL_W'(rx_fill_ew);
    tx_fill_d  = FILL_W'(tx_fill_ew);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      action_q <= action_i;
      data_q   <= data_byte_i;
      idle_q   <= tx_idle_i;
    end
    if (cmd_i.commit) begin
      read_data_q  <= read_data_d;
      read_valid_q <= read_valid_d;
      accepted_q   <= accepted_d;
      send_data_q  <= send_data_d;
      send_valid_q <= send_valid_d;
      dropped_q    <= dropped_d;
      rx_fill_q    <= rx_fill_d;
      tx_fill_q    <= tx_fill_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rx_size_q <= SIZE_RESET;
      tx_size_q <= SIZE_RESET;
      rx_wp_q   <= '0;
      rx_rp_q   <= '0;
      tx_wp_q   <= '0;
      tx_rp_q   <= '0;
    end else if (cfg_we_i) begin
      // a size write empties its ring
      if (cfg_index_i == REG_RX_RING_SIZE) begin
        rx_size_q <= cfg_data_i;
        rx_wp_q   <= '0;
        rx_rp_q   <= '0;
      end else begin
        tx_size_q <= cfg_data_i;
        tx_wp_q   <= '0;
        tx_rp_q   <= '0;
      end
    end else if (cmd_i.commit) begin
      rx_wp_q <= rx_wp_d;
      rx_rp_q <= rx_rp_d;
      tx_wp_q <= tx_wp_d;
      tx_rp_q <= tx_rp_d;
    end
  end

  assign read_data_o      = read_data_q;
  assign read_valid_o     = read_valid_q;
  assign write_accepted_o = accepted_q;
  assign send_data_o      = send_data_q;
  assign send_valid_o     = send_valid_q;
  assign rx_dropped_o     = dropped_q;
  assign rx_fill_o        = rx_fill_q;
  assign tx_fill_o        = tx_fill_q;

endmodule

`default_nettype wire

// ===== sv/uart_rx_tx_ring_buffer.sv =====
// Byte buffering for one serial port: a receive ring and a transmit ring, each held in a
// single-port-write, registered-read RAM of RX_DEPTH / TX_DEPTH bytes. One input transfer
// carries one action (byte received, host read, host peek, host write, transmitter ready)
// and yields exactly one result transfer with the returned or sent byte, the status flags
// and both fill counts after the step. Each item is captured, which lets the ring RAMs
// present the oldest byte at their registered read port, then committed, which updates
// the positions and loads the result register. The result register parts the two sides,
// so a new item is taken while an earlier result still waits under out stall. Register 0
// sets the receive ring length and register 1 the transmit ring length (clamped to
// 2..depth, one byte fewer usable); writing either empties that ring. Write them only
// while no item is in flight. The RAMs need no clearing after reset: a read only reaches
// bytes written since the ring was last empty.
`default_nettype none

`include "uart_rx_tx_ring_buffer_assert.svh"

module uart_rx_tx_ring_buffer
  import urtrb_pkg::*;
#(
  parameter int RX_DEPTH = RX_DEPTH_DEF,
  parameter int TX_DEPTH = TX_DEPTH_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  // item input
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire logic [ACT_W-1:0]     action_i,
  input  wire logic [DATA_W-1:0]    data_byte_i,
  input  wire logic                 tx_idle_i,
  // result output
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output logic      [DATA_W-1:0]    read_data_o,
  output logic                      read_valid_o,
  output logic                      write_accepted_o,
  output logic      [DATA_W-1:0]    send_data_o,
  output logic                      send_valid_o,
  output logic                      rx_dropped_o,
  output logic      [FILL_W-1:0]    rx_fill_o,
  output logic      [FILL_W-1:0]    tx_fill_o,
  // register writes
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [CFG_W-1:0]     cfg_data_i
);

  ctl_cmd_t cmd;

  // sequencer: capture, then commit once the result register is free or being emptied
  urtrb_ctl u_ctl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  // rings, positions, size registers and result payload
  urtrb_dp #(
    .RX_DEPTH (RX_DEPTH),
    .TX_DEPTH (TX_DEPTH)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .action_i         (action_i),
    .data_byte_i      (data_byte_i),
    .tx_idle_i        (tx_idle_i),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .read_data_o      (read_data_o),
    .read_valid_o     (read_valid_o),
    .write_accepted_o (write_accepted_o),
    .send_data_o      (send_data_o),
    .send_valid_o     (send_valid_o),
    .rx_dropped_o     (rx_dropped_o),
    .rx_fill_o        (rx_fill_o),
    .tx_fill_o        (tx_fill_o)
  );

  // a committed step always shows up as a result on the next cycle
  `ASSERT_NXT(a_commit_gives_result, cmd.commit, out_valid_o,
              "committed step did not raise out_valid")
  // the sequencer never captures and commits at once
  `ASSERT_CLK(a_capture_commit_excl, !(cmd.capture && cmd.commit),
              "capture and commit in the same cycle")
  // a read result never comes with a send, a drop or a write acceptance
  `ASSERT_IMP(a_read_excl, out_valid_o && read_valid_o,
              !send_valid_o && !rx_dropped_o && !write_accepted_o,
              "read result mixed with another action's flags")

endmodule

`default_nettype wire

// ===== sim/uart_rx_tx_ring_buffer_tb.sv =====
`timescale 1ns / 100ps

// Testbench for the serial-port ring buffer.
// A directed list of items runs first, then randomised traffic in phases that vary the
// ring sizes and the idling on both channels. Every result transfer is checked field by
// field against a fixed answer or a behavioural model of the two rings kept here.
module uart_rx_tx_ring_buffer_tb;
  import urtrb_pkg::*;

  // One result transfer, in port order
  typedef struct packed {
    logic [DATA_W-1:0] read_data;
    logic              read_valid;
    logic              write_accepted;
    logic [DATA_W-1:0] send_data;
    logic              send_valid;
    logic              rx_dropped;
    logic [FILL_W-1:0] rx_fill;
    logic [FILL_W-1:0] tx_fill;
  } status_t;

  // A directed row is either a register write or an item; fixed rows carry their answer
  typedef struct {
    bit                is_cfg;
    cfg_reg_e          reg_idx;
    logic [CFG_W-1:0]  reg_val;
    logic [ACT_W-1:0]  act;
    logic [DATA_W-1:0] octet;
    logic              idle;
    bit                fixed;
    status_t           want;
  } dir_row_t;

  localparam int RING_MAX    = 64;
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 112;
  localparam int HOLD_CYCLES = 300;
  localparam int UNUSED_LO   = 5;
  localparam int UNUSED_HI   = 7;

  // Register settings per phase; the last two phases draw random values
  localparam int RX_PLAN [PHASES] = '{64, 2, 127, 0, 1, 65, 5, 9};
  localparam int TX_PLAN [PHASES] = '{64, 1, 2, 127, 65, 0, 7, 3};

  // Block ports
  logic                 clk_i          = 1'b0;
  logic                 rst_ni         = 1'b0;
  logic                 in_valid_i     = 1'b0;
  logic                 in_stall_o;
  logic [ACT_W-1:0]     action_i       = '0;
  logic [DATA_W-1:0]    data_byte_i    = '0;
  logic                 tx_idle_i      = 1'b0;
  logic                 out_valid_o;
  logic                 out_stall_i    = 1'b0;
  logic [DATA_W-1:0]    read_data_o;
  logic                 read_valid_o;
  logic                 write_accepted_o;
  logic [DATA_W-1:0]    send_data_o;
  logic                 send_valid_o;
  logic                 rx_dropped_o;
  logic [FILL_W-1:0]    rx_fill_o;
  logic [FILL_W-1:0]    tx_fill_o;
  logic                 cfg_we_i       = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index_i    = '0;
  logic [CFG_W-1:0]     cfg_data_i     = '0;

  // Model of the rings: byte stores, positions and size registers
  logic [DATA_W-1:0] rx_mem [RING_MAX];
  logic [DATA_W-1:0] tx_mem [RING_MAX];
  int                rx_wp, rx_rp, tx_wp, tx_rp;
  logic [CFG_W-1:0]  rx_size_reg = SIZE_RESET;
  logic [CFG_W-1:0]  tx_size_reg = SIZE_RESET;

  status_t  expected_q [$];
  dir_row_t directed_rows [$];

  int mismatch_count  = 0;
  int results_checked = 0;
  int items_sent      = 0;
  int drops_seen      = 0;
  int sends_seen      = 0;
  int settings_used   = 0;

  // Idling controls, set per phase by the stimulus thread
  int sender_idle_pct = 0;
  int recv_stall_pct  = 0;
  int hold_req        = 0;
  int hold_seen       = 0;
  int hold_left       = 0;

  uart_rx_tx_ring_buffer dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .action_i         (action_i),
    .data_byte_i      (data_byte_i),
    .tx_idle_i        (tx_idle_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .read_data_o      (read_data_o),
    .read_valid_o     (read_valid_o),
    .write_accepted_o (write_accepted_o),
    .send_data_o      (send_data_o),
    .send_valid_o     (send_valid_o),
    .rx_dropped_o     (rx_dropped_o),
    .rx_fill_o        (rx_fill_o),
    .tx_fill_o        (tx_fill_o),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Model of the buffer
  // ---------------------------------------------------------------------------

  // Size register clamped to the usable range 2..depth
  function automatic int ring_len(logic [CFG_W-1:0] size_reg);
    if (size_reg < 2) return 2;
    if (size_reg > RING_MAX) return RING_MAX;
    return int'(size_reg);
  endfunction

  // Oldest queued transmit byte, if any, goes to the transmitter
  function automatic bit tx_take(int ts, output logic [DATA_W-1:0] octet);
    octet = '0;
    if (tx_wp == tx_rp) return 1'b0;
    octet = tx_mem[tx_rp];
    tx_rp = (tx_rp + 1) % ts;
    return 1'b1;
  endfunction

  // Applies one item to the model and returns the status transfer it should produce
  function automatic status_t predict_buffer_step(logic [ACT_W-1:0] act,
                                                  logic [DATA_W-1:0] octet, logic idle);
    status_t s;
    int rs, ts, nxt;
    logic [DATA_W-1:0] sent;
    s  = '0;
    rs = ring_len(rx_size_reg);
    ts = ring_len(tx_size_reg);
    case (act)
      ACT_RX_BYTE: begin
        // full ring: the oldest unread byte makes room
        nxt = (rx_wp + 1) % rs;
        if (nxt == rx_rp) begin
          rx_rp        = (rx_rp + 1) % rs;
          s.rx_dropped = 1'b1;
        end
        rx_mem[rx_wp] = octet;
        rx_wp         = nxt;
      end
      ACT_HOST_READ, ACT_HOST_PEEK: begin
        if (rx_wp != rx_rp) begin
          s.read_data  = rx_mem[rx_rp];
          s.read_valid = 1'b1;
          if (act == ACT_HOST_READ) rx_rp = (rx_rp + 1) % rs;
        end
      end
      ACT_HOST_WRITE: begin
        if (tx_wp == tx_rp && idle) begin
          // empty ring and idle transmitter: straight out
          s.send_data      = octet;
          s.send_valid     = 1'b1;
          s.write_accepted = 1'b1;
        end else if ((tx_wp + 1) % ts != tx_rp) begin
          tx_mem[tx_wp]    = octet;
          tx_wp            = (tx_wp + 1) % ts;
          s.write_accepted = 1'b1;
          if (idle) begin
            s.send_valid = tx_take(ts, sent);
            s.send_data  = sent;
          end
        end
      end
      ACT_TX_READY: begin
        s.send_valid = tx_take(ts, sent);
        s.send_data  = sent;
      end
      default: ;
    endcase
    s.rx_fill = FILL_W'((rs + rx_wp - rx_rp) % rs);
    s.tx_fill = FILL_W'((ts + tx_wp - tx_rp) % ts);
    return s;
  endfunction

  // ---------------------------------------------------------------------------
  // Directed list helpers
  // ---------------------------------------------------------------------------

  function automatic status_t outcome(logic [DATA_W-1:0] rd, logic rv, logic wa,
                                      logic [DATA_W-1:0] sd, logic sv, logic drop,
                                      logic [FILL_W-1:0] rxf, logic [FILL_W-1:0] txf);
    return {rd, rv, wa, sd, sv, drop, rxf, txf};
  endfunction

  function automatic void add_op(logic [ACT_W-1:0] act, logic [DATA_W-1:0] octet,
                                 logic idle, bit fixed, status_t want);
    dir_row_t r;
    r        = '{reg_idx: REG_RX_RING_SIZE, default: '0};
    r.act    = act;
    r.octet  = octet;
    r.idle   = idle;
    r.fixed  = fixed;
    r.want   = want;
    directed_rows.push_back(r);
  endfunction

  function automatic void add_cfg(cfg_reg_e idx, logic [CFG_W-1:0] val);
    dir_row_t r;
    r         = '{reg_idx: REG_RX_RING_SIZE, default: '0};
    r.is_cfg  = 1'b1;
    r.reg_idx = idx;
    r.reg_val = val;
    directed_rows.push_back(r);
  endfunction

  // ---------------------------------------------------------------------------
  // Input side: transfers driven at the falling edge, acceptance seen at the rising edge
  // ---------------------------------------------------------------------------

  // Offers one item, with a random gap first; returns at the edge that accepts it.
  // valid is left high so back-to-back items never drop it in between.
  task automatic push_item(logic [ACT_W-1:0] act, logic [DATA_W-1:0] octet, logic idle,
                           bit fixed, status_t want);
    status_t pred;
    @(negedge clk_i);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    action_i    <= act;
    data_byte_i <= octet;
    tx_idle_i   <= idle;
    do @(posedge clk_i); while (in_stall_o);
    pred = predict_buffer_step(act, octet, idle);
    expected_q.push_back(fixed ? want : pred);
    items_sent++;
  endtask

  // Stops offering, waits for every outstanding result, then lets the pipeline settle
  task automatic quiesce();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Register write; the ring concerned is emptied in the model as in the block
  task automatic cfg_write(cfg_reg_e idx, logic [CFG_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    if (idx == REG_RX_RING_SIZE) begin
      rx_size_reg = val;
      rx_wp       = 0;
      rx_rp       = 0;
    end else begin
      tx_size_reg = val;
      tx_wp       = 0;
      tx_rp       = 0;
    end
  endtask

  // Random action; the bias alternates so that the rings both fill up and run dry
  function automatic logic [ACT_W-1:0] pick_action(bit fill_bias);
    int r;
    r = $urandom_range(99);
    if (r >= 95) return ACT_W'($urandom_range(UNUSED_HI, UNUSED_LO));
    if (fill_bias) begin
      if (r < 35) return ACT_RX_BYTE;
      if (r < 65) return ACT_HOST_WRITE;
      if (r < 75) return ACT_HOST_READ;
      if (r < 83) return ACT_HOST_PEEK;
      return ACT_TX_READY;
    end
    if (r < 15) return ACT_RX_BYTE;
    if (r < 30) return ACT_HOST_WRITE;
    if (r < 55) return ACT_HOST_READ;
    if (r < 65) return ACT_HOST_PEEK;
    return ACT_TX_READY;
  endfunction

  // ---------------------------------------------------------------------------
  // Output side: stall driven at the falling edge; a long hold-off on request
  // ---------------------------------------------------------------------------

  always @(negedge clk_i) begin
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left   = hold_left - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
      mismatch_count++;
    end
  endfunction

  // Every accepted result transfer is compared with the oldest expectation
  always @(posedge clk_i) begin : result_check
    status_t got, want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = {read_data_o, read_valid_o, write_accepted_o, send_data_o, send_valid_o,
             rx_dropped_o, rx_fill_o, tx_fill_o};
      if (expected_q.size() == 0) begin
        $display("%0t ns: result transfer with nothing expected, actual %h", $time, got);
        mismatch_count++;
      end else begin
        want = expected_q.pop_front();
        check_field("read_data", want.read_data, got.read_data);
        check_field("read_valid", want.read_valid, got.read_valid);
        check_field("write_accepted", want.write_accepted, got.write_accepted);
        check_field("send_data", want.send_data, got.send_data);
        check_field("send_valid", want.send_valid, got.send_valid);
        check_field("rx_dropped", want.rx_dropped, got.rx_dropped);
        check_field("rx_fill", want.rx_fill, got.rx_fill);
        check_field("tx_fill", want.tx_fill, got.tx_fill);
        results_checked++;
        if (want.rx_dropped) drops_seen++;
        if (want.send_valid) sends_seen++;
      end
    end
  end

  // Generous limit; a correct run needs a small fraction of it
  initial begin
    #3_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  initial begin
    dir_row_t          row;
    logic [CFG_W-1:0]  rx_set, tx_set;
    logic [ACT_W-1:0]  act;
    status_t           none;
    none = '0;

    // Directed list. Fresh after reset both rings are 64 long.
    // Empty rings: peek, read and transmitter ready find nothing
    add_op(ACT_HOST_PEEK,  8'h00, 1'b0, 1'b1, outcome(8'h00, 0, 0, 8'h00, 0, 0, 0, 0));
    add_op(ACT_HOST_READ,  8'h00, 1'b0, 1'b1, outcome(8'h00, 0, 0, 8'h00, 0, 0, 0, 0));
    add_op(ACT_TX_READY,   8'h00, 1'b1, 1'b1, outcome(8'h00, 0, 0, 8'h00, 0, 0, 0, 0));
    add_op(ACT_W'(UNUSED_LO), 8'hFF, 1'b1, 1'b1,
           outcome(8'h00, 0, 0, 8'h00, 0, 0, 0, 0));
    // Receive path with data extremes
    add_op(ACT_RX_BYTE,    8'hFF, 1'b0, 1'b1, outcome(8'h00, 0, 0, 8'h00, 0, 0, 1, 0));
    add_op(ACT_RX_BYTE,    8'h00, 1'b1, 1'b1, outcome(8'h00, 0, 0, 8'h00, 0, 0, 2, 0));
    add_op(ACT_HOST_PEEK,  8'h00, 1'b0, 1'b1, outcome(8'hFF, 1, 0, 8'h00, 0, 0, 2, 0));
    add_op(ACT_HOST_READ,  8'h00, 1'b0, 1'b1, outcome(8'hFF, 1, 0, 8'h00, 0, 0, 1, 0));
    add_op(ACT_HOST_READ,  8'h00, 1'b0, 1'b1, outcome(8'h00, 1, 0, 8'h00, 0, 0, 0, 0));
    // Transmit path: straight out, queued, queued, queued with a kick, then drained
    add_op(ACT_HOST_WRITE, 8'hA5, 1'b1, 1'b1, outcome(8'h00, 0, 1, 8'hA5, 1, 0, 0, 0));
    add_op(ACT_HOST_WRITE, 8'h5A, 1'b0, 1'b1, outcome(8'h00, 0, 1, 8'h00, 0, 0, 0, 1));
    add_op(ACT_HOST_WRITE, 8'h3C, 1'b0, 1'b1, outcome(8'h00, 0, 1, 8'h00, 0, 0, 0, 2));
    add_op(ACT_HOST_WRITE, 8'h81, 1'b1, 1'b1, outcome(8'h00, 0, 1, 8'h5A, 1, 0, 0, 2));
    add_op(ACT_TX_READY,   8'h00, 1'b0, 1'b1, outcome(8'h00, 0, 0, 8'h3C, 1, 0, 0, 1));
    add_op(ACT_TX_READY,   8'h00, 1'b0, 1'b1, outcome(8'h00, 0, 0, 8'h81, 1, 0, 0, 0));
    add_op(ACT_W'(UNUSED_HI), 8'h00, 1'b0, 1'b1,
           outcome(8'h00, 0, 0, 8'h00, 0, 0, 0, 0));
    // Sizes below the minimum act as 2: one usable byte per ring
    add_cfg(REG_RX_RING_SIZE, 7'd0);
    add_cfg(REG_TX_RING_SIZE, 7'd1);
    add_op(ACT_RX_BYTE,    8'h11, 1'b0, 1'b1, outcome(8'h00, 0, 0, 8'h00, 0, 0, 1, 0));
    // full receive ring: the unread byte is overwritten
    add_op(ACT_RX_BYTE,    8'h22, 1'b0, 1'b1, outcome(8'h00, 0, 0, 8'h00, 0, 1, 1, 0));
    add_op(ACT_W'(UNUSED_HI - 1), 8'h7E, 1'b1, 1'b1,
           outcome(8'h00, 0, 0, 8'h00, 0, 0, 1, 0));
    add_op(ACT_HOST_READ,  8'h00, 1'b0, 1'b1, outcome(8'h22, 1, 0, 8'h00, 0, 0, 0, 0));
    add_op(ACT_HOST_WRITE, 8'h33, 1'b0, 1'b0, none);
    // full transmit ring: rejected whether or not the transmitter is idle
    add_op(ACT_HOST_WRITE, 8'h44, 1'b0, 1'b1, outcome(8'h00, 0, 0, 8'h00, 0, 0, 0, 1));
    add_op(ACT_HOST_WRITE, 8'h55, 1'b1, 1'b1, outcome(8'h00, 0, 0, 8'h00, 0, 0, 0, 1));
    add_op(ACT_TX_READY,   8'h00, 1'b0, 1'b1, outcome(8'h00, 0, 0, 8'h33, 1, 0, 0, 0));
    // Sizes above the depth act as the depth
    add_cfg(REG_RX_RING_SIZE, 7'd127);
    add_cfg(REG_TX_RING_SIZE, 7'd65);

    rx_wp = 0;
    rx_rp = 0;
    tx_wp = 0;
    tx_rp = 0;

    // Reset: held low, then released on a falling edge
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed list walked with no idling on either side
    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      if (row.is_cfg) begin
        quiesce();
        cfg_write(row.reg_idx, row.reg_val);
        settings_used++;
      end else begin
        push_item(row.act, row.octet, row.idle, row.fixed, row.want);
      end
    end

    // Random phases: the idling mode cycles, the ring sizes change each phase
    for (int ph = 0; ph < PHASES; ph++) begin
      quiesce();
      rx_set = (ph >= 6) ? CFG_W'($urandom_range(127)) : CFG_W'(RX_PLAN[ph]);
      tx_set = (ph >= 6) ? CFG_W'($urandom_range(127)) : CFG_W'(TX_PLAN[ph]);
      cfg_write(REG_RX_RING_SIZE, rx_set);
      cfg_write(REG_TX_RING_SIZE, tx_set);
      settings_used++;
      case (ph % 4)
        0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin sender_idle_pct = 79; recv_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  recv_stall_pct = 79; end
        default: begin sender_idle_pct = 20; recv_stall_pct = 20; end
      endcase
      // receiver holds off for a long stretch while the sender keeps offering,
      // so the block backs up and stalls its input transfers
      if (ph % 4 == 0) hold_req++;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // sender pauses mid-phase until every outstanding result has come back
        if (n == PHASE_ITEMS / 2) quiesce();
        act = pick_action((n / 20) % 2 == 0);
        push_item(act, DATA_W'($urandom_range(255)), 1'($urandom_range(1)), 1'b0, none);
      end
    end

    quiesce();
    repeat (10) @(posedge clk_i);
    $display("Covered %0d items over %0d ring settings: %0d results checked,",
             items_sent, settings_used, results_checked);
    $display("  %0d receive overwrites and %0d bytes handed to the transmitter.",
             drops_seen, sends_seen);
    if (mismatch_count == 0 && expected_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== uart_rx_tx_ring_buffer.f =====
+incdir+sv
sv/urtrb_pkg.sv
sv/urtrb_ram.sv
sv/urtrb_ctl.sv
sv/urtrb_dp.sv
sv/uart_rx_tx_ring_buffer.sv
sim/uart_rx_tx_ring_buffer_tb.sv
